[sv/e321_pkg.sv]
// shared types, constants and helper functions for the euler 3-2-1 rotation block
`default_nettype none
package e321_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int DATA_BITS_DEF  = 16;

    localparam int CORDIC_STEPS = 17;
    localparam int XY_W         = 33;
    localparam int Z_W          = 22;
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 15;

    localparam logic signed [XY_W-1:0] CORDIC_ONE = XY_W'(652032874);
    localparam logic signed [XY_W-1:0] RND_HALF   = XY_W'(16384);
    localparam logic signed [XY_W-1:0] COEF_MAX   = XY_W'(32767);
    localparam logic signed [XY_W-1:0] COEF_MIN   = -XY_W'(32768);

    // atan(2^-i) in units of 2^-20 turn
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        Z_W'(131072), Z_W'(77376), Z_W'(40884), Z_W'(20753), Z_W'(10417),
        Z_W'(5213), Z_W'(2607), Z_W'(1304), Z_W'(652), Z_W'(326), Z_W'(163),
        Z_W'(81), Z_W'(41), Z_W'(20), Z_W'(10), Z_W'(5), Z_W'(3)
    };

    typedef struct packed {
        logic                   neg;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } lane_t;

    // fold into the right half turn and start the rotation from the gain-compensated unit
    function automatic lane_t cordic_init(input logic [31:0] turn);
        lane_t       l;
        logic [31:0] tf;
        l.neg = turn[31] ^ turn[30];
        tf = turn ^ {l.neg, 31'b0};
        l.x = CORDIC_ONE;
        l.y = '0;
        l.z = Z_W'($signed(tf[31:12]));
        return l;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_round(
        input logic signed [XY_W-1:0] v,
        input logic                   neg
    );
        logic signed [XY_W-1:0] vn;
        logic signed [XY_W-1:0] r;
        logic signed [COEF_W-1:0] res;
        vn = neg ? -v : v;
        r = (vn + RND_HALF) >>> FRAC_BITS;
        if (r > COEF_MAX) begin
            res = COEF_W'(COEF_MAX);
        end else if (r < COEF_MIN) begin
            res = COEF_W'(COEF_MIN);
        end else begin
            res = COEF_W'(r);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/e321_cordic_cell.sv]
// one cordic micro-rotation cell with its pipeline register
`default_nettype none
module e321_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                   aclk,
    input  wire                   en,
    input  wire e321_pkg::lane_t  lane_i,
    output e321_pkg::lane_t       lane_o
);

    e321_pkg::lane_t lane_reg;
    e321_pkg::lane_t lane_next;
    logic signed [e321_pkg::XY_W-1:0] xs;
    logic signed [e321_pkg::XY_W-1:0] ys;

    always_comb begin
        xs = lane_i.x >>> STEP;
        ys = lane_i.y >>> STEP;
        lane_next.neg = lane_i.neg;
        // zero residual counts as positive
        if (!lane_i.z[e321_pkg::Z_W-1]) begin
            lane_next.x = lane_i.x - ys;
            lane_next.y = lane_i.y + xs;
            lane_next.z = lane_i.z - e321_pkg::ATAN_TAB[STEP];
        end else begin
            lane_next.x = lane_i.x + ys;
            lane_next.y = lane_i.y - xs;
            lane_next.z = lane_i.z + e321_pkg::ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule
`default_nettype wire

[sv/e321_planar_cell.sv]
// one planar rotation cell: a' = c*a + s*b, b' = c*b - s*a, rounded half up
`default_nettype none
module e321_planar_cell #(
    parameter int IW = 20
) (
    input  wire                                     aclk,
    input  wire                                     en,
    input  wire signed [IW-1:0]                     a_i,
    input  wire signed [IW-1:0]                     b_i,
    input  wire signed [e321_pkg::COEF_W-1:0]       c_i,
    input  wire signed [e321_pkg::COEF_W-1:0]       s_i,
    output logic signed [IW-1:0]                    a_o,
    output logic signed [IW-1:0]                    b_o
);

    localparam int SW = IW + e321_pkg::COEF_W + 1;

    logic signed [SW-1:0] sum_a;
    logic signed [SW-1:0] sum_b;
    logic signed [SW-1:0] rnd_a;
    logic signed [SW-1:0] rnd_b;
    logic signed [IW-1:0] a_reg;
    logic signed [IW-1:0] b_reg;
    logic signed [IW-1:0] a_next;
    logic signed [IW-1:0] b_next;

    always_comb begin
        sum_a = SW'(c_i) * SW'(a_i) + SW'(s_i) * SW'(b_i);
        sum_b = SW'(c_i) * SW'(b_i) - SW'(s_i) * SW'(a_i);
        rnd_a = (sum_a + SW'(16384)) >>> e321_pkg::FRAC_BITS;
        rnd_b = (sum_b + SW'(16384)) >>> e321_pkg::FRAC_BITS;
        a_next = IW'(rnd_a);
        b_next = IW'(rnd_b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign a_o = a_reg;
    assign b_o = b_reg;

endmodule
`default_nettype wire

[sv/euler_321_vector_rotation.sv]
// Euler 3-2-1 vector rotation (yaw, pitch, roll) of a 3-D vector with a pass-through fourth
// component. Fully pipelined: one item per cycle while the pipeline advances (input fold stage,
// 17 cordic cells per angle, coefficient rounding stage, three planar rotation cells).
// The whole pipeline advances when the output register is empty or being taken, so
// s_ready follows m_ready combinationally. Angles are binary angles (2^ANGLE_BITS is a
// full turn); x, y, z results are rounded and saturated to DATA_BITS+2 bits.
`default_nettype none
module euler_321_vector_rotation #(
    parameter int ANGLE_BITS = e321_pkg::ANGLE_BITS_DEF,
    parameter int DATA_BITS  = e321_pkg::DATA_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire signed [ANGLE_BITS-1:0]  s_roll_angle,
    input  wire signed [ANGLE_BITS-1:0]  s_pitch_angle,
    input  wire signed [ANGLE_BITS-1:0]  s_yaw_angle,
    input  wire signed [DATA_BITS-1:0]   s_vec_x,
    input  wire signed [DATA_BITS-1:0]   s_vec_y,
    input  wire signed [DATA_BITS-1:0]   s_vec_z,
    input  wire signed [DATA_BITS-1:0]   s_vec_w,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [DATA_BITS+1:0]  m_out_x,
    output logic signed [DATA_BITS+1:0]  m_out_y,
    output logic signed [DATA_BITS+1:0]  m_out_z,
    output logic signed [DATA_BITS-1:0]  m_out_w
);

    localparam int IW = DATA_BITS + 4;
    localparam int OB = DATA_BITS + 2;
    localparam int CS = e321_pkg::CORDIC_STEPS + 1;
    localparam int NS = CS + 4;
    localparam int CW = e321_pkg::COEF_W;

    logic en;
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;

    // lanes: 0 roll, 1 pitch, 2 yaw
    e321_pkg::lane_t lane [CS][3];
    e321_pkg::lane_t init_reg [3];
    logic signed [DATA_BITS-1:0] vec_reg [CS][4];
    logic signed [CW-1:0] coef_c_reg [3];
    logic signed [CW-1:0] coef_s_reg [3];
    logic signed [DATA_BITS-1:0] vec_c_reg [4];

    assign en = !vld_reg[NS-1] || m_ready;
    assign s_ready = en;

    always_comb begin
        vld_next = {vld_reg[NS-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // input fold stage
    always_ff @(posedge aclk) begin
        if (en) begin
            init_reg[0] <= e321_pkg::cordic_init(32'($unsigned(s_roll_angle)) << (32 - ANGLE_BITS));
            init_reg[1] <= e321_pkg::cordic_init(32'($unsigned(s_pitch_angle)) << (32 - ANGLE_BITS));
            init_reg[2] <= e321_pkg::cordic_init(32'($unsigned(s_yaw_angle)) << (32 - ANGLE_BITS));
            vec_reg[0][0] <= s_vec_x;
            vec_reg[0][1] <= s_vec_y;
            vec_reg[0][2] <= s_vec_z;
            vec_reg[0][3] <= s_vec_w;
        end
    end

    assign lane[0][0] = init_reg[0];
    assign lane[0][1] = init_reg[1];
    assign lane[0][2] = init_reg[2];

    genvar gi, gl;
    generate
        for (gi = 0; gi < e321_pkg::CORDIC_STEPS; gi++) begin : g_step
            for (gl = 0; gl < 3; gl++) begin : g_lane
                e321_cordic_cell #(.STEP(gi)) u_cell (
                    .aclk   (aclk),
                    .en     (en),
                    .lane_i (lane[gi][gl]),
                    .lane_o (lane[gi+1][gl])
                );
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    vec_reg[gi+1] <= vec_reg[gi];
                end
            end
        end
    endgenerate

    // coefficient rounding stage
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                coef_c_reg[k] <= e321_pkg::coef_round(lane[CS-1][k].x, lane[CS-1][k].neg);
                coef_s_reg[k] <= e321_pkg::coef_round(lane[CS-1][k].y, lane[CS-1][k].neg);
            end
            vec_c_reg <= vec_reg[CS-1];
        end
    end

    // yaw on (x,y)
    logic signed [IW-1:0] x1, y1;
    logic signed [IW-1:0] z1_reg;
    logic signed [DATA_BITS-1:0] w1_reg;
    logic signed [CW-1:0] cp1_reg, sp1_reg, cr1_reg, sr1_reg;

    e321_planar_cell #(.IW(IW)) u_yaw (
        .aclk (aclk), .en (en),
        .a_i  (IW'(vec_c_reg[0])), .b_i (IW'(vec_c_reg[1])),
        .c_i  (coef_c_reg[2]), .s_i (coef_s_reg[2]),
        .a_o  (x1), .b_o (y1)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg  <= IW'(vec_c_reg[2]);
            w1_reg  <= vec_c_reg[3];
            cp1_reg <= coef_c_reg[1];
            sp1_reg <= coef_s_reg[1];
            cr1_reg <= coef_c_reg[0];
            sr1_reg <= coef_s_reg[0];
        end
    end

    // pitch on (z,x)
    logic signed [IW-1:0] z2, x2;
    logic signed [IW-1:0] y2_reg;
    logic signed [DATA_BITS-1:0] w2_reg;
    logic signed [CW-1:0] cr2_reg, sr2_reg;

    e321_planar_cell #(.IW(IW)) u_pitch (
        .aclk (aclk), .en (en),
        .a_i  (z1_reg), .b_i (x1),
        .c_i  (cp1_reg), .s_i (sp1_reg),
        .a_o  (z2), .b_o (x2)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            y2_reg  <= y1;
            w2_reg  <= w1_reg;
            cr2_reg <= cr1_reg;
            sr2_reg <= sr1_reg;
        end
    end

    // roll on (y,z)
    logic signed [IW-1:0] y3, z3;
    logic signed [IW-1:0] x3_reg;
    logic signed [DATA_BITS-1:0] w3_reg;

    e321_planar_cell #(.IW(IW)) u_roll (
        .aclk (aclk), .en (en),
        .a_i  (y2_reg), .b_i (z2),
        .c_i  (cr2_reg), .s_i (sr2_reg),
        .a_o  (y3), .b_o (z3)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            x3_reg <= x2;
            w3_reg <= w2_reg;
        end
    end

    function automatic logic signed [OB-1:0] sat_out(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] hi;
        logic signed [IW-1:0] lo;
        logic signed [OB-1:0] r;
        hi = IW'({1'b0, {(OB-1){1'b1}}});
        lo = -hi - IW'(1);
        if (v > hi) begin
            r = OB'(hi);
        end else if (v < lo) begin
            r = OB'(lo);
        end else begin
            r = OB'(v);
        end
        return r;
    endfunction

    assign m_valid = vld_reg[NS-1];
    assign m_out_x = sat_out(x3_reg);
    assign m_out_y = sat_out(y3);
    assign m_out_z = sat_out(z3);
    assign m_out_w = w3_reg;

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("pipeline advance does not follow output side");
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
